// File: rtl/core/pn2d_pkg.sv
// ----------------------------------------------------------------------------
// pn2d_pkg: shared types and constants for the 2D gradient noise pipeline
// Fixed-point format, stream widths, stage enables and the rounding multiply.
// ----------------------------------------------------------------------------
package pn2d_pkg;

  // Coordinate and table geometry
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int IDX_W      = 8;
  localparam int PERM_W     = 8;
  localparam int TABLE_SIZE = 256;
  localparam int OUT_W      = 16;

  // Stream widths: x, y, table index, table value from the lowest bit up
  localparam int S_DATA_W   = 2 * COORD_W + IDX_W + PERM_W;
  localparam int M_DATA_W   = OUT_W;

  // Internal signed fixed point with FRAC_BITS fraction bits
  localparam int FX_W       = 24;
  localparam int PROD_W     = 2 * FX_W;

  typedef logic signed [FX_W-1:0]   fx_t;
  typedef logic [FRAC_BITS-1:0]     frac_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [PERM_W-1:0]        perm_t;

  localparam fx_t FX_ONE     = fx_t'(64'sd1 <<< FRAC_BITS);
  localparam fx_t FADE_C6    = fx_t'(6);
  localparam fx_t FADE_C15   = fx_t'(15 * (64'sd1 <<< FRAC_BITS));
  localparam fx_t FADE_C10   = fx_t'(10 * (64'sd1 <<< FRAC_BITS));
  localparam logic [PROD_W-1:0] PROD_HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));

  // Request kinds carried on tuser
  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_EVAL  = 1'b1
  } req_t;

  // Load enables of the pipeline stages shared with the fade unit
  typedef struct packed {
    logic b;
    logic c;
    logic d;
  } pn2d_adv_t;

  // Fixed-point multiply, round to nearest with ties away from zero
  function automatic fx_t fx_mul(fx_t a, fx_t b);
    logic signed [PROD_W-1:0] p;
    logic [PROD_W-1:0]        mag;
    logic [PROD_W-1:0]        r;
    fx_t                      rr;
    p   = PROD_W'(a) * PROD_W'(b);
    mag = p[PROD_W-1] ? unsigned'(-p) : unsigned'(p);
    r   = (mag + PROD_HALF) >> FRAC_BITS;
    rr  = signed'(r[FX_W-1:0]);
    return p[PROD_W-1] ? -rr : rr;
  endfunction

endpackage

// File: rtl/core/pn2d_ram.sv
// ----------------------------------------------------------------------------
// pn2d_ram: generic single-write, dual-read RAM
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module pn2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/core/pn2d_fade.sv
// ----------------------------------------------------------------------------
// pn2d_fade: quintic fade curve, three stages
// Computes 6t^5-15t^4+10t^3 as t*t*t*(t*(6t-15)+10), clamped to [0,1], with
// stage 1 multiplying twice. Stages follow the main pipeline enables b, c, d.
// ----------------------------------------------------------------------------
module pn2d_fade (
  input  logic              clk,
  input  pn2d_pkg::pn2d_adv_t adv,
  input  pn2d_pkg::frac_t   t_in,
  output pn2d_pkg::fx_t     fade
);
  import pn2d_pkg::*;

  fx_t t_s;
  fx_t inner;
  fx_t t_b;
  fx_t t2_b;
  fx_t m_b;
  fx_t t3_c;
  fx_t m_c;
  fx_t f_raw;

  // Widen the fraction to the internal format
  assign t_s   = fx_t'(signed'({{(FX_W - FRAC_BITS){1'b0}}, t_in}));
  assign inner = FADE_C6 * t_s - FADE_C15;

  // First stage: t*(6t-15)+10 and t*t
  always_ff @(posedge clk) begin
    if (adv.b) begin
      t_b  <= t_s;
      t2_b <= fx_mul(t_s, t_s);
      m_b  <= fx_mul(t_s, inner) + FADE_C10;
    end
  end

  // Second stage: t^3
  always_ff @(posedge clk) begin
    if (adv.c) begin
      t3_c <= fx_mul(t2_b, t_b);
      m_c  <= m_b;
    end
  end

  // Third stage: final product and clamp
  assign f_raw = fx_mul(t3_c, m_c);

  always_ff @(posedge clk) begin
    if (adv.d) begin
      if (f_raw < 0) begin
        fade <= '0;
      end else if (f_raw > FX_ONE) begin
        fade <= FX_ONE;
      end else begin
        fade <= f_raw;
      end
    end
  end

endmodule

// File: rtl/core/perlin_noise_2d.sv
// ----------------------------------------------------------------------------
// perlin_noise_2d: pipelined 2D gradient noise evaluator
// Table-write items load the 256-entry permutation table; evaluate items
// return one noise sample in unsigned Q0.16 each.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (lowest bit up)                           | tuser
//  ---------+-----+-------------------------------------------------+---------
//  s_*      | in  | coord_x[31:0] coord_y[63:32] index[71:64]       | req_type
//           |     | value[79:72]                                    |
//  m_*      | out | noise_value[15:0]                               | -
//
//  Throughput is one item per cycle while the output is not stalled; each
//  item passes five register stages, A to E, and the output register.
//  Table copies are read and written at the same stage, so a write affects
//  exactly the items behind it.
//  Each stage loads when it is empty or the stage after it moves; a stalled
//  output only stops the stages that are full. Reset clears the valid bits;
//  table contents are undefined until written. Write items leave no result.
// ----------------------------------------------------------------------------
module perlin_noise_2d (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // coord_x, coord_y, table_index, table_value
  input  logic [pn2d_pkg::S_DATA_W-1:0] s_tdata,
  // req_type
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // noise_value
  output logic [pn2d_pkg::M_DATA_W-1:0] m_tdata
);
  import pn2d_pkg::*;

  // Gradient of one corner: +-u +-v picked by the low hash bits
  function automatic fx_t grad(logic [1:0] h, fx_t x, fx_t y);
    fx_t a;
    fx_t b;
    a = h[1] ? y : x;
    b = h[1] ? x : y;
    return (h[0] ? -a : a) + (h[1] ? -b : b);
  endfunction

  // Map [-1,1] to unsigned Q0.16, rounded and saturated
  function automatic logic [OUT_W-1:0] to_q16(fx_t res);
    fx_t                     n;
    logic [FX_W+OUT_W-1:0]   w;
    n = res + FX_ONE;
    w = ({{OUT_W{1'b0}}, n} << OUT_W) + {{OUT_W{1'b0}}, FX_ONE};
    w = w >> (FRAC_BITS + 1);
    if (n <= 0) begin
      return '0;
    end else if (w > {{FX_W{1'b0}}, {OUT_W{1'b1}}}) begin
      return '1;
    end else begin
      return w[OUT_W-1:0];
    end
  endfunction

  // Stage enables
  logic      adv_a;
  logic      adv_o;
  pn2d_adv_t adv;
  pn2d_adv_t fade_adv;

  // Stage A: captured item
  logic  vld_a;
  req_t  kind_a;
  idx_t  cx_a;
  idx_t  cy_a;
  frac_t fx_a;
  frac_t fy_a;
  idx_t  widx_a;
  perm_t wval_a;

  // Stage B: first-level table reads
  logic  vld_b;
  req_t  kind_b;
  idx_t  cy_b;
  frac_t fx_b;
  frac_t fy_b;
  idx_t  widx_b;
  perm_t wval_b;
  perm_t px_b;
  perm_t px1_b;
  idx_t  cy1_b;

  // Stage C: corner hashes
  logic  vld_c;
  frac_t fx_c;
  frac_t fy_c;
  perm_t h00_c;
  perm_t h01_c;
  perm_t h10_c;
  perm_t h11_c;
  fx_t   x0_c;
  fx_t   x1_c;
  fx_t   y0_c;
  fx_t   y1_c;

  // Stage D: gradients and fades
  logic  vld_d;
  fx_t   g00_d;
  fx_t   g10_d;
  fx_t   g01_d;
  fx_t   g11_d;
  fx_t   u_d;
  fx_t   v_d;

  // Stage E: x-axis blends
  logic  vld_e;
  fx_t   lx0_e;
  fx_t   lx1_e;
  fx_t   v_e;
  fx_t   res_e;

  // Ready chain from the output register back to the input
  assign adv_o    = !m_tvalid || m_tready;
  assign adv.d    = !vld_e || adv_o;
  assign adv.c    = !vld_d || adv.d;
  assign adv.b    = !vld_c || adv.c;
  assign adv_a    = !vld_b || adv.b;
  assign s_tready = !vld_a || adv_a;

  // Fade stages load together with stages B, C and D
  assign fade_adv = '{b: adv_a, c: adv.b, d: adv.c};

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a    <= 1'b0;
      vld_b    <= 1'b0;
      vld_c    <= 1'b0;
      vld_d    <= 1'b0;
      vld_e    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        vld_a <= s_tvalid;
      end
      if (adv_a) begin
        vld_b <= vld_a;
      end
      // drop write items once both table levels have taken them
      if (adv.b) begin
        vld_c <= vld_b && (kind_b == REQ_EVAL);
      end
      if (adv.c) begin
        vld_d <= vld_c;
      end
      if (adv.d) begin
        vld_e <= vld_d;
      end
      if (adv_o) begin
        m_tvalid <= vld_e;
      end
    end
  end

  // Stage A: split coordinates into cell and fraction
  always_ff @(posedge clk) begin
    if (s_tready) begin
      kind_a <= req_t'(s_tuser);
      fx_a   <= s_tdata[FRAC_BITS-1:0];
      cx_a   <= s_tdata[FRAC_BITS +: IDX_W];
      fy_a   <= s_tdata[COORD_W +: FRAC_BITS];
      cy_a   <= s_tdata[COORD_W + FRAC_BITS +: IDX_W];
      widx_a <= s_tdata[2*COORD_W +: IDX_W];
      wval_a <= s_tdata[2*COORD_W + IDX_W +: PERM_W];
    end
  end

  // First-level table copy: perm[X] and perm[X+1]
  pn2d_ram #(
    .WIDTH (PERM_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram_l1 (
    .clk     (clk),
    .we      (vld_a && (kind_a == REQ_WRITE) && adv_a),
    .waddr   (widx_a),
    .wdata   (wval_a),
    .re      (adv_a),
    .raddr_a (cx_a),
    .raddr_b (cx_a + idx_t'(1)),
    .rdata_a (px_b),
    .rdata_b (px1_b)
  );

  // Stage B: carry fields alongside the first-level read
  always_ff @(posedge clk) begin
    if (adv_a) begin
      kind_b <= kind_a;
      cy_b   <= cy_a;
      fx_b   <= fx_a;
      fy_b   <= fy_a;
      widx_b <= widx_a;
      wval_b <= wval_a;
    end
  end

  assign cy1_b = cy_b + idx_t'(1);

  // Second-level copies: hashes of the four corners
  pn2d_ram #(
    .WIDTH (PERM_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram_l2x0 (
    .clk     (clk),
    .we      (vld_b && (kind_b == REQ_WRITE) && adv.b),
    .waddr   (widx_b),
    .wdata   (wval_b),
    .re      (adv.b),
    .raddr_a (px_b + cy_b),
    .raddr_b (px_b + cy1_b),
    .rdata_a (h00_c),
    .rdata_b (h01_c)
  );

  pn2d_ram #(
    .WIDTH (PERM_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram_l2x1 (
    .clk     (clk),
    .we      (vld_b && (kind_b == REQ_WRITE) && adv.b),
    .waddr   (widx_b),
    .wdata   (wval_b),
    .re      (adv.b),
    .raddr_a (px1_b + cy_b),
    .raddr_b (px1_b + cy1_b),
    .rdata_a (h10_c),
    .rdata_b (h11_c)
  );

  // Stage C: carry fractions
  always_ff @(posedge clk) begin
    if (adv.b) begin
      fx_c <= fx_b;
      fy_c <= fy_b;
    end
  end

  // Fade curves, aligned to stage D
  pn2d_fade u_fade_x (
    .clk  (clk),
    .adv  (fade_adv),
    .t_in (fx_a),
    .fade (u_d)
  );

  pn2d_fade u_fade_y (
    .clk  (clk),
    .adv  (fade_adv),
    .t_in (fy_a),
    .fade (v_d)
  );

  // Corner offsets in fixed point
  assign x0_c = fx_t'(signed'({{(FX_W - FRAC_BITS){1'b0}}, fx_c}));
  assign y0_c = fx_t'(signed'({{(FX_W - FRAC_BITS){1'b0}}, fy_c}));
  assign x1_c = x0_c - FX_ONE;
  assign y1_c = y0_c - FX_ONE;

  // Stage D: corner gradients
  always_ff @(posedge clk) begin
    if (adv.c) begin
      g00_d <= grad(h00_c[1:0], x0_c, y0_c);
      g10_d <= grad(h10_c[1:0], x1_c, y0_c);
      g01_d <= grad(h01_c[1:0], x0_c, y1_c);
      g11_d <= grad(h11_c[1:0], x1_c, y1_c);
    end
  end

  // Stage E: blend along x
  always_ff @(posedge clk) begin
    if (adv.d) begin
      lx0_e <= g00_d + fx_mul(u_d, g10_d - g00_d);
      lx1_e <= g01_d + fx_mul(u_d, g11_d - g01_d);
      v_e   <= v_d;
    end
  end

  // Blend along y and normalize into the output register
  assign res_e = lx0_e + fx_mul(v_e, lx1_e - lx0_e);

  always_ff @(posedge clk) begin
    if (adv_o) begin
      m_tdata <= to_q16(res_e);
    end
  end

endmodule

// File: rtl/core/pn2d_check.sv
// ----------------------------------------------------------------------------
// pn2d_check: port-level checks for the noise pipeline
// Tracks evaluate items in flight and checks results against them.
// ----------------------------------------------------------------------------
module pn2d_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // Five stages plus the output register
  localparam int MAX_PENDING = 6;

  logic [3:0] pending;
  logic       eval_in;
  logic       res_out;

  assign eval_in = s_tvalid && s_tready && s_tuser;
  assign res_out = m_tvalid && m_tready;

  // Count evaluate items not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {3'b000, eval_in} - {3'b000, res_out};
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 4'd0)
    else $error("result without an evaluate item");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'(MAX_PENDING))
    else $error("more evaluate items in flight than stages");

endmodule

bind perlin_noise_2d pn2d_check u_check (.*);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for perlin_noise_2d
// Loads the permutation table, then streams directed and random evaluate and
// table-write items under varying stalls on both sides, predicts every noise
// sample from a local copy of the table and compares each result in order.
// ----------------------------------------------------------------------------
module testbench;
  import pn2d_pkg::*;

  localparam longint ONE_Q   = longint'(1) << FRAC_BITS;
  localparam int     HOLD_CYC = 300;

  typedef struct {
    req_t                kind;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    idx_t                idx;
    perm_t               val;
    bit                  wait_idle;
  } noise_req_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  noise_req_t        pending[$];
  noise_req_t        cur_req;
  logic [OUT_W-1:0]  noise_due[$];
  perm_t             perm_copy[TABLE_SIZE];

  int total_items = 0;
  int sent_cnt    = 0;
  int write_cnt   = 0;
  int eval_cnt    = 0;
  int check_cnt   = 0;
  int err_cnt     = 0;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  wire rx_hold    = (hold_left != 0);

  perlin_noise_2d dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock and the single reset pulse
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Fixed-point product, rounded to nearest with ties away from zero
  function automatic longint round_mul(longint a, longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned r;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    r  = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  // Quintic fade t^3 * (t * (6t - 15) + 10), clamped to [0,1]
  function automatic longint fade_curve(longint t);
    longint f;
    f = round_mul(round_mul(round_mul(t, t), t),
                  round_mul(t, 6 * t - 15 * ONE_Q) + 10 * ONE_Q);
    if (f < 0) f = 0;
    if (f > ONE_Q) f = ONE_Q;
    return f;
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + round_mul(t, b - a);
  endfunction

  // Corner gradient: hash bit 1 swaps the axes, bits 0 and 1 flip the signs
  function automatic longint corner_dot(perm_t h, longint dx, longint dy);
    longint a;
    longint b;
    a = h[1] ? dy : dx;
    b = h[1] ? dx : dy;
    return (h[0] ? -a : a) + (h[1] ? -b : b);
  endfunction

  function automatic perm_t lattice_hash(idx_t cx, idx_t cy);
    idx_t s;
    s = perm_copy[cx] + cy;
    return perm_copy[s];
  endfunction

  // Noise sample at one point, from the local table copy
  function automatic logic [OUT_W-1:0] noise_at(logic [COORD_W-1:0] x,
                                                logic [COORD_W-1:0] y);
    idx_t            cx;
    idx_t            cy;
    idx_t            cx1;
    idx_t            cy1;
    longint          fx;
    longint          fy;
    longint          u;
    longint          v;
    longint          g00;
    longint          g10;
    longint          g01;
    longint          g11;
    longint          res;
    longint unsigned q;
    // floor then modulo the table size keeps just these bits
    cx  = x[FRAC_BITS +: IDX_W];
    cy  = y[FRAC_BITS +: IDX_W];
    cx1 = cx + idx_t'(1);
    cy1 = cy + idx_t'(1);
    fx  = longint'(x[FRAC_BITS-1:0]);
    fy  = longint'(y[FRAC_BITS-1:0]);
    u   = fade_curve(fx);
    v   = fade_curve(fy);
    g00 = corner_dot(lattice_hash(cx, cy), fx, fy);
    g10 = corner_dot(lattice_hash(cx1, cy), fx - ONE_Q, fy);
    g01 = corner_dot(lattice_hash(cx, cy1), fx, fy - ONE_Q);
    g11 = corner_dot(lattice_hash(cx1, cy1), fx - ONE_Q, fy - ONE_Q);
    res = blend(v, blend(u, g00, g10), blend(u, g01, g11)) + ONE_Q;
    // map [-1,1] onto Q0.16 with rounding and saturation
    if (res <= 0) begin
      q = 0;
    end else begin
      q = ((unsigned'(res) << OUT_W) + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
      if (q > 65535) q = 65535;
    end
    return q[OUT_W-1:0];
  endfunction

  // Apply one accepted item to the local table or the result queue
  task automatic accept_req(noise_req_t r);
    if (r.kind == REQ_WRITE) begin
      perm_copy[r.idx] = r.val;
      write_cnt++;
    end else begin
      noise_due.push_back(noise_at(r.x, r.y));
      eval_cnt++;
    end
  endtask

  task automatic queue_req(req_t kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           idx_t idx, perm_t val, bit wait_idle);
    noise_req_t r;
    r.kind      = kind;
    r.x         = x;
    r.y         = y;
    r.idx       = idx;
    r.val       = val;
    r.wait_idle = wait_idle;
    pending.push_back(r);
  endtask

  // Random coordinate, often pushed to fraction extremes or the lattice wrap
  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] c;
    c = $urandom();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: c[FRAC_BITS-1:0] = '0;
          1: c[FRAC_BITS-1:0] = '1;
          2: c[FRAC_BITS-1:0] = 16'h8000;
          default: c[FRAC_BITS-1:0] = 16'h0001;
        endcase
      end
      1: c[FRAC_BITS +: IDX_W] = $urandom_range(1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return c;
  endfunction

  // Idle rates by run phase: sender light, then receiver light, then none
  always_comb begin
    if (sent_cnt < total_items / 3) begin
      tx_idle_pct = 8;
      rx_idle_pct = 46;
    end else if (sent_cnt < 2 * total_items / 3) begin
      tx_idle_pct = 46;
      rx_idle_pct = 8;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  end

  // Driver: retire the accepted item, then offer the next one
  always @(posedge clk) begin : drive_proc
    bit offer;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        accept_req(cur_req);
        sent_cnt++;
        offer = 1'b0;
      end
      if (!offer && pending.size() != 0 && $urandom_range(99) >= tx_idle_pct &&
          !(pending[0].wait_idle && noise_due.size() != 0)) begin
        cur_req = pending.pop_front();
        s_tdata <= {cur_req.val, cur_req.idx, cur_req.y, cur_req.x};
        s_tuser <= cur_req.kind;
        offer = 1'b1;
      end
      s_tvalid <= offer;
    end
  end

  // Long receiver hold-off late in the run, with the sender still offering
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && total_items != 0 && sent_cnt >= (total_items * 4) / 5) begin
      hold_left <= HOLD_CYC;
      hold_done <= 1'b1;
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin : watch_proc
    logic [OUT_W-1:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (noise_due.size() == 0) begin
          err_cnt++;
          $error("noise_value: no result pending, got %0d", m_tdata);
        end else begin
          want = noise_due.pop_front();
          check_cnt++;
          if (m_tdata !== want) begin
            err_cnt++;
            $error("noise_value: expected %0d, got %0d", want, m_tdata);
          end
        end
      end
      m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Stimulus and end of run
  initial begin : stim_proc
    perm_t vals[TABLE_SIZE];
    idx_t  slots[TABLE_SIZE];
    perm_t tv;
    idx_t  ti;
    int    j;
    bit    hold;

    // load a shuffled permutation in shuffled order
    for (int i = 0; i < TABLE_SIZE; i++) begin
      vals[i]  = perm_t'(i);
      slots[i] = idx_t'(i);
    end
    for (int i = TABLE_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tv = vals[i]; vals[i] = vals[j]; vals[j] = tv;
      j = $urandom_range(i);
      ti = slots[i]; slots[i] = slots[j]; slots[j] = ti;
    end
    for (int i = 0; i < TABLE_SIZE; i++)
      queue_req(REQ_WRITE, $urandom(), $urandom(), slots[i], vals[i], 1'b0);

    // coordinate extremes, fraction edges and lattice wrap in both directions
    queue_req(REQ_EVAL, 32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00, 1'b1);
    queue_req(REQ_EVAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF, 8'hFF, 1'b0);
    queue_req(REQ_EVAL, 32'h8000_0000, 32'h8000_0000, 8'h00, 8'hFF, 1'b0);
    queue_req(REQ_EVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'h00, 1'b0);
    queue_req(REQ_EVAL, 32'hFFFF_8000, 32'h00FF_C000, 8'h00, 8'h00, 1'b0);
    queue_req(REQ_EVAL, 32'h0000_FFFF, 32'h0001_0000, 8'h00, 8'h00, 1'b0);
    queue_req(REQ_EVAL, 32'h7FFF_0000, 32'h8000_FFFF, 8'h00, 8'h00, 1'b0);
    queue_req(REQ_EVAL, 32'h0000_8000, 32'hFFFF_0001, 8'h00, 8'h00, 1'b0);
    // extreme writes at both table ends, read back right behind them
    queue_req(REQ_WRITE, 32'h0, 32'h0, 8'h00, 8'hFF, 1'b0);
    queue_req(REQ_WRITE, 32'h0, 32'h0, 8'hFF, 8'h00, 1'b0);
    queue_req(REQ_EVAL, 32'h00FF_4000, 32'h00FF_4000, 8'h00, 8'h00, 1'b0);
    queue_req(REQ_EVAL, 32'h0000_C000, 32'h00FF_2000, 8'h00, 8'h00, 1'b0);
    // craft cell (10,20) so its four corners use all four gradients
    queue_req(REQ_WRITE, 32'h0, 32'h0, 8'd10, 8'd100, 1'b0);
    queue_req(REQ_WRITE, 32'h0, 32'h0, 8'd11, 8'd110, 1'b0);
    queue_req(REQ_WRITE, 32'h0, 32'h0, 8'd120, 8'd0, 1'b0);
    queue_req(REQ_WRITE, 32'h0, 32'h0, 8'd121, 8'd1, 1'b0);
    queue_req(REQ_WRITE, 32'h0, 32'h0, 8'd130, 8'd2, 1'b0);
    queue_req(REQ_WRITE, 32'h0, 32'h0, 8'd131, 8'd3, 1'b0);
    queue_req(REQ_EVAL, 32'h000A_8000, 32'h0014_8000, 8'h00, 8'h00, 1'b0);
    queue_req(REQ_EVAL, 32'h000A_4000, 32'h0014_C000, 8'h00, 8'h00, 1'b0);
    queue_req(REQ_EVAL, 32'h000A_0001, 32'h0014_FFFF, 8'h00, 8'h00, 1'b0);

    // random mix, mostly evaluations, with occasional drains
    for (int i = 0; i < 1070; i++) begin
      hold = (i == 360) || (i == 720) || ($urandom_range(99) == 0);
      if ($urandom_range(99) < 12)
        queue_req(REQ_WRITE, $urandom(), $urandom(), idx_t'($urandom_range(255)),
                  perm_t'($urandom_range(255)), hold);
      else
        queue_req(REQ_EVAL, rand_coord(), rand_coord(), idx_t'($urandom_range(255)),
                  perm_t'($urandom_range(255)), hold);
    end
    total_items = pending.size();

    // wait for all items, all results, then a latency margin
    while (sent_cnt != total_items) @(posedge clk);
    while (noise_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d table writes and %0d evaluations under mixed stalls;",
             write_cnt, eval_cnt);
    $display("checked %0d noise samples, %0d mismatches.", check_cnt, err_cnt);
    if (err_cnt == 0)
      $display("perlin_noise_2d verification clean");
    else
      $display("perlin_noise_2d verification failed");
    $finish;
  end

  // Hang guard
  initial begin
    #400000;
    $display("perlin_noise_2d verification failed");
    $finish;
  end

endmodule
